// ----- design/assert_macros.svh -----
// Assertion macros shared by the row run gap filler RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rrgf_pkg.sv -----
// Package for the row run gap filler: job type, register indexes and constants.
// Used by rrgf_row_tracker and row_run_gap_filler_core; depends on nothing.
package rrgf_pkg;

    localparam int PIXEL_W = 32;
    localparam int USER_OUT_W = 5;

    localparam logic [PIXEL_W-1:0] FILL_VALUE_RESET = 32'h3F80_0000;
    localparam logic FILL_ENABLE_RESET = 1'b1;
    localparam logic [PIXEL_W-1:0] POS_ZERO = '0;

    localparam logic REG_IDX_FILL_VALUE = 1'b0;
    localparam logic REG_IDX_FILL_ENABLE = 1'b1;

    // One output burst: held pixels first, then the final pixel that carries the flags.
    typedef struct packed {
        logic [PIXEL_W-1:0] hold_pixel;
        logic [PIXEL_W-1:0] final_pixel;
        logic               row_done;
        logic               frame_done;
        logic               row_had_gaps;
        logic               frame_ready;
        logic               row_overflow;
    } rrgf_job_t;

endpackage

// ----- design/rrgf_row_tracker.sv -----
// Row state of the gap filler: run, held zero and column tracking per row.
// Turns each accepted pixel into an output job, except a held zero that ends no row; depends on rrgf_pkg.
module rrgf_row_tracker #(
    parameter int MAX_COLS = 64,
    parameter int COL_W = 7,
    parameter int HELD_W = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_fire,
    input  logic [rrgf_pkg::PIXEL_W-1:0]   pixel_value,
    input  logic                           row_end,
    input  logic                           frame_end,
    input  logic [rrgf_pkg::PIXEL_W-1:0]   fill_value,
    input  logic                           fill_enable,
    output logic                           job_valid,
    output logic [HELD_W-1:0]              job_count,
    output rrgf_pkg::rrgf_job_t            job
);

    logic              run_started_reg, run_started_next;
    logic              prev_nonzero_reg, prev_nonzero_next;
    logic [HELD_W-1:0] held_zeros_reg, held_zeros_next;
    logic [1:0]        run_count_reg, run_count_next;
    logic [COL_W-1:0]  column_count_reg, column_count_next;
    logic              frame_ok_reg, frame_ok_next;

    logic             re;
    logic             nz;
    logic             over;
    logic             held_case;
    logic             gaps;
    logic             frame_ok_tmp;
    logic [1:0]       run_count_new;
    logic [COL_W-1:0] column_step;

    always_comb begin
        re = row_end | frame_end;
        nz = |pixel_value[rrgf_pkg::PIXEL_W-2:0];
        over = column_count_reg >= COL_W'(MAX_COLS);
        column_step = over ? COL_W'(MAX_COLS + 1) : column_count_reg + COL_W'(1);
        run_count_new = (nz && !prev_nonzero_reg && run_count_reg < 2'd2)
                        ? run_count_reg + 2'd1 : run_count_reg;
        held_case = !nz && run_started_reg && fill_enable && !over;
        gaps = run_count_new >= 2'd2;
        frame_ok_tmp = frame_ok_reg & ~gaps;

        job_valid = !held_case || re;
        job_count = held_zeros_reg;
        job.hold_pixel = (nz && fill_enable && !over) ? fill_value : rrgf_pkg::POS_ZERO;
        job.final_pixel = held_case ? rrgf_pkg::POS_ZERO : pixel_value;
        job.row_done = re;
        job.frame_done = frame_end;
        job.row_had_gaps = re & gaps;
        job.frame_ready = frame_end & frame_ok_tmp;
        job.row_overflow = re & over;
    end

    always_comb begin
        run_started_next = run_started_reg;
        prev_nonzero_next = prev_nonzero_reg;
        held_zeros_next = held_zeros_reg;
        run_count_next = run_count_reg;
        column_count_next = column_count_reg;
        frame_ok_next = frame_ok_reg;
        if (in_fire) begin
            if (re) begin
                run_started_next = 1'b0;
                prev_nonzero_next = 1'b0;
                held_zeros_next = '0;
                run_count_next = '0;
                column_count_next = '0;
                frame_ok_next = frame_end ? 1'b1 : frame_ok_tmp;
            end else begin
                run_started_next = run_started_reg | nz;
                prev_nonzero_next = nz;
                held_zeros_next = held_case ? held_zeros_reg + HELD_W'(1) : '0;
                run_count_next = run_count_new;
                column_count_next = column_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_started_reg <= 1'b0;
            prev_nonzero_reg <= 1'b0;
            held_zeros_reg <= '0;
            run_count_reg <= '0;
            column_count_reg <= '0;
            frame_ok_reg <= 1'b1;
        end else begin
            run_started_reg <= run_started_next;
            prev_nonzero_reg <= prev_nonzero_next;
            held_zeros_reg <= held_zeros_next;
            run_count_reg <= run_count_next;
            column_count_reg <= column_count_next;
            frame_ok_reg <= frame_ok_next;
        end
    end

endmodule

// ----- design/row_run_gap_filler_core.sv -----
// Top level of the row run gap filler: APB registers, burst stage and output register.
// Depends on rrgf_pkg, rrgf_row_tracker and assert_macros.svh.
//
// Channel   | Direction | Payload
// s_axis    | in        | tdata pixel_value, tlast row_end, tuser frame_end
// m_axis    | out       | tdata pixel_out, tlast row_done, tuser flags
// apb       | in/out    | fill_value at 0x0, fill_enable at 0x4
//
// A pixel's results leave one per cycle while the output register is empty or m_tready is high.
// A pixel that releases held zeros occupies the burst stage until its final pixel leaves,
// and the input stalls meanwhile; otherwise one pixel enters every cycle unless the output stalls.
// A held zero that ends no row produces no transaction.
// Reset is synchronous and active low; it clears the row state and both stages.
`include "assert_macros.svh"

module row_run_gap_filler_core #(
    parameter int MAX_COLS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rrgf_pkg::PIXEL_W-1:0]        s_tdata,   // [31:0] pixel_value
    input  logic                                s_tlast,   // row_end
    input  logic                                s_tuser,   // frame_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rrgf_pkg::PIXEL_W-1:0]        m_tdata,   // [31:0] pixel_out
    output logic                                m_tlast,   // row_done
    // [0] frame_done, [1] burst_last, [2] row_had_gaps, [3] frame_ready, [4] row_overflow
    output logic [rrgf_pkg::USER_OUT_W-1:0]     m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int COL_W = $clog2(MAX_COLS + 2);
    localparam int HELD_W = $clog2(MAX_COLS);

    logic [rrgf_pkg::PIXEL_W-1:0] fill_value_reg;
    logic                         fill_enable_reg;

    logic                in_fire;
    logic                job_valid;
    logic [HELD_W-1:0]   job_count;
    rrgf_pkg::rrgf_job_t job;

    logic                burst_valid_reg, burst_valid_next;
    logic [HELD_W-1:0]   burst_cnt_reg, burst_cnt_next;
    rrgf_pkg::rrgf_job_t burst_job_reg;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [rrgf_pkg::PIXEL_W-1:0]    m_tdata_reg;
    logic                            m_tlast_reg;
    logic [rrgf_pkg::USER_OUT_W-1:0] m_tuser_reg;

    logic out_ok;
    logic beat;
    logic final_beat;
    logic burst_end;
    logic cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_value_reg <= rrgf_pkg::FILL_VALUE_RESET;
            fill_enable_reg <= rrgf_pkg::FILL_ENABLE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                rrgf_pkg::REG_IDX_FILL_VALUE:  fill_value_reg <= pwdata;
                rrgf_pkg::REG_IDX_FILL_ENABLE: fill_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rrgf_pkg::REG_IDX_FILL_VALUE:  prdata = fill_value_reg;
            rrgf_pkg::REG_IDX_FILL_ENABLE: prdata = {31'd0, fill_enable_reg};
            default:                       prdata = '0;
        endcase
    end

    rrgf_row_tracker #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W),
        .HELD_W   (HELD_W)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .pixel_value (s_tdata),
        .row_end     (s_tlast),
        .frame_end   (s_tuser),
        .fill_value  (fill_value_reg),
        .fill_enable (fill_enable_reg),
        .job_valid   (job_valid),
        .job_count   (job_count),
        .job         (job)
    );

    always_comb begin
        out_ok = !m_tvalid_reg || m_tready;
        beat = burst_valid_reg && out_ok;
        final_beat = burst_cnt_reg == '0;
        burst_end = beat && final_beat;
        s_tready = !burst_valid_reg || burst_end;
        in_fire = s_tvalid && s_tready;
    end

    always_comb begin
        burst_valid_next = burst_valid_reg;
        burst_cnt_next = burst_cnt_reg;
        priority if (in_fire && job_valid) begin
            burst_valid_next = 1'b1;
            burst_cnt_next = job_count;
        end else if (burst_end) begin
            burst_valid_next = 1'b0;
        end else if (beat) begin
            burst_cnt_next = burst_cnt_reg - HELD_W'(1);
        end
        m_tvalid_next = beat ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_valid_reg <= 1'b0;
            burst_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            burst_valid_reg <= burst_valid_next;
            burst_cnt_reg <= burst_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && job_valid) begin
            burst_job_reg <= job;
        end
        if (beat) begin
            m_tdata_reg <= final_beat ? burst_job_reg.final_pixel : burst_job_reg.hold_pixel;
            m_tlast_reg <= final_beat & burst_job_reg.row_done;
            m_tuser_reg <= final_beat ? {burst_job_reg.row_overflow,
                                         burst_job_reg.frame_ready,
                                         burst_job_reg.row_had_gaps,
                                         1'b1,
                                         burst_job_reg.frame_done}
                                      : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tuser = m_tuser_reg;

    `ASSERT_IMP(a_row_done_is_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1], "row_done on a transaction that is not the last of its burst")
    `ASSERT_IMP(a_stall_needs_burst, aclk, aresetn, !s_tready, burst_valid_reg && !burst_end, "input stalled without a burst in progress")
    `ASSERT_NEXT(a_burst_continues, aclk, aresetn, beat && !final_beat, burst_valid_reg, "burst dropped before its final transaction")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for row_run_gap_filler_core: directed rows, then random rows.
// Predicts every released pixel and its flags; depends on rrgf_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int ROW_MAX = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_PIXELS = 40;
    localparam int PHASE_COUNT = 8;
    localparam logic [2:0] ADDR_FILL_VALUE = {rrgf_pkg::REG_IDX_FILL_VALUE, 2'b00};
    localparam logic [2:0] ADDR_FILL_ENABLE = {rrgf_pkg::REG_IDX_FILL_ENABLE, 2'b00};

    typedef struct packed {
        logic [rrgf_pkg::PIXEL_W-1:0] pixel;
        logic                         row_end;
        logic                         frame_end;
    } pixel_in_t;

    typedef struct packed {
        logic [rrgf_pkg::PIXEL_W-1:0] pixel;
        logic                         row_done;
        logic                         frame_done;
        logic                         burst_last;
        logic                         row_had_gaps;
        logic                         frame_ready;
        logic                         row_overflow;
    } pixel_out_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rrgf_pkg::PIXEL_W-1:0]     s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             s_tuser = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rrgf_pkg::PIXEL_W-1:0]     m_tdata;
    logic                             m_tlast;
    logic [rrgf_pkg::USER_OUT_W-1:0]  m_tuser;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [2:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    pixel_in_t  pixel_q[$];
    pixel_out_t released_q[$];
    int         fail_count = 0;
    int         cycle_count = 0;

    logic       tx_gaps_on = 1'b0;
    logic       rx_stalls_on = 1'b0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_cnt = 0;
    int         gap_left = 0;
    int         burst_left = 0;
    logic [15:0] rx_pat = 16'hFFFF;
    int         rx_step = 0;

    logic [rrgf_pkg::PIXEL_W-1:0] cfg_fill_value = rrgf_pkg::FILL_VALUE_RESET;
    logic                         cfg_fill_enable = rrgf_pkg::FILL_ENABLE_RESET;
    logic                         row_started = 1'b0;
    logic                         last_nonzero = 1'b0;
    int                           held_count = 0;
    int                           run_count = 0;
    int                           col_count = 0;
    logic                         frame_clean = 1'b1;

    row_run_gap_filler_core #(.MAX_COLS(ROW_MAX)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic fill_row_pixel(input pixel_in_t px);
        pixel_out_t burst[$];
        pixel_out_t r;
        logic       fe;
        logic       re;
        logic       nz;
        logic       over;
        logic       gaps;
        logic [rrgf_pkg::PIXEL_W-1:0] gap_pixel;
        fe = px.frame_end;
        re = px.row_end | fe;
        nz = |px.pixel[rrgf_pkg::PIXEL_W-2:0];
        over = col_count >= ROW_MAX;
        col_count = over ? ROW_MAX + 1 : col_count + 1;
        r = '0;
        if (nz) begin
            if (!last_nonzero && run_count < 2) run_count++;
            gap_pixel = (cfg_fill_enable && !over) ? cfg_fill_value : rrgf_pkg::POS_ZERO;
            r.pixel = gap_pixel;
            repeat (held_count) burst = {burst, r};
            held_count = 0;
            r.pixel = px.pixel;
            burst = {burst, r};
            row_started = 1'b1;
            last_nonzero = 1'b1;
        end else begin
            last_nonzero = 1'b0;
            if (row_started && cfg_fill_enable && !over) begin
                held_count++;
            end else begin
                r.pixel = rrgf_pkg::POS_ZERO;
                repeat (held_count) burst = {burst, r};
                held_count = 0;
                r.pixel = px.pixel;
                burst = {burst, r};
            end
        end
        if (re) begin
            r.pixel = rrgf_pkg::POS_ZERO;
            repeat (held_count) burst = {burst, r};
            held_count = 0;
            gaps = run_count >= 2;
            r = burst[burst.size()-1];
            r.row_done = 1'b1;
            r.row_had_gaps = gaps;
            r.row_overflow = col_count > ROW_MAX;
            if (gaps) frame_clean = 1'b0;
            if (fe) begin
                r.frame_done = 1'b1;
                r.frame_ready = frame_clean;
                frame_clean = 1'b1;
            end
            burst[burst.size()-1] = r;
            row_started = 1'b0;
            last_nonzero = 1'b0;
            run_count = 0;
            col_count = 0;
        end
        if (burst.size() > 0) begin
            r = burst[burst.size()-1];
            r.burst_last = 1'b1;
            burst[burst.size()-1] = r;
        end
        released_q = {released_q, burst};
    endtask

    task automatic send(input logic [rrgf_pkg::PIXEL_W-1:0] pix, input logic re,
                        input logic fe);
        pixel_in_t px;
        px.pixel = pix;
        px.row_end = re;
        px.frame_end = fe;
        fill_row_pixel(px);
        pixel_q = {pixel_q, px};
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || released_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_FILL_VALUE) cfg_fill_value = data;
        else if (addr == ADDR_FILL_ENABLE) cfg_fill_enable = data[0];
    endtask

    function automatic logic [rrgf_pkg::PIXEL_W-1:0] rand_nonzero();
        logic [rrgf_pkg::PIXEL_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 11))
            0: v = 32'h0000_0001;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h8000_0001;
            default: ;
        endcase
        if (v[rrgf_pkg::PIXEL_W-2:0] == '0) v[0] = 1'b1;
        return v;
    endfunction

    task automatic gen_row(input int len, input logic close, output int sent);
        int style;
        int zero_pct;
        logic re;
        logic fe;
        logic [rrgf_pkg::PIXEL_W-1:0] v;
        style = $urandom_range(0, 9);
        zero_pct = (style < 3) ? 10 : (style < 9) ? 50 : 100;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < zero_pct)
                v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
            else
                v = rand_nonzero();
            re = 1'b0;
            fe = 1'b0;
            if (close && i == len - 1) begin
                fe = ($urandom_range(0, 5) == 0);
                re = fe ? 1'($urandom_range(0, 1)) : 1'b1;
            end
            send(v, re, fe);
        end
        sent = len;
    endtask

    always @(posedge aclk) begin : drive_proc
        logic offer;
        offer = s_tvalid;
        if (!aresetn) begin
            offer = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(pixel_q.pop_front());
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_q.size() > 0) begin
                    offer = 1'b1;
                    if (tx_gaps_on) begin
                        if (burst_left == 0) burst_left = $urandom_range(1, 12);
                        burst_left--;
                        if (burst_left == 0) gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
        s_tvalid <= offer;
        if (offer) begin
            s_tdata <= pixel_q[0].pixel;
            s_tlast <= pixel_q[0].row_end;
            s_tuser <= pixel_q[0].frame_end;
        end
    end

    always @(posedge aclk) begin : recv_proc
        logic rdy;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        rx_step++;
        if (rx_step % 16 == 0) begin
            rx_pat = 16'($urandom);
            if (rx_pat == '0) rx_pat[0] = 1'b1;
        end else begin
            rx_pat = {rx_pat[0], rx_pat[15:1]};
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
        end else if (!rx_stalls_on) begin
            rdy = 1'b1;
        end else begin
            rdy = rx_pat[0];
        end
        m_tready <= rdy;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_proc
        pixel_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (released_q.size() == 0) begin
                $error("transaction with no expected pixel: pixel_out %h", m_tdata);
                fail_count++;
            end else begin
                want = released_q.pop_front();
                check_field("pixel_out", want.pixel, m_tdata);
                check_field("row_done", 32'(want.row_done), 32'(m_tlast));
                check_field("frame_done", 32'(want.frame_done), 32'(m_tuser[0]));
                check_field("burst_last", 32'(want.burst_last), 32'(m_tuser[1]));
                check_field("row_had_gaps", 32'(want.row_had_gaps), 32'(m_tuser[2]));
                check_field("frame_ready", 32'(want.frame_ready), 32'(m_tuser[3]));
                check_field("row_overflow", 32'(want.row_overflow), 32'(m_tuser[4]));
            end
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int total;
        int n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(ADDR_FILL_VALUE, 32'hC000_0000);
        write_reg(ADDR_FILL_ENABLE, 32'h1);
        send(32'h8000_0000, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b0);
        send(32'h3F80_0000, 1'b0, 1'b0);
        send(32'h8000_0000, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b0);
        send(32'hFFFF_FFFF, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b0);
        send(32'h8000_0000, 1'b1, 1'b0);
        send(32'h0000_0001, 1'b1, 1'b0);
        send(32'h7FFF_FFFF, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b1);
        send(32'h1234_5678, 1'b1, 1'b1);
        send(32'h8000_0000, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b1, 1'b0);
        send(32'h4000_0000, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b0);
        send(32'h8000_0000, 1'b0, 1'b0);
        wait_idle();
        write_reg(ADDR_FILL_ENABLE, 32'h0);
        send(32'h4040_0000, 1'b0, 1'b0);
        send(32'h0000_0000, 1'b0, 1'b0);
        send(32'hBF80_0000, 1'b1, 1'b0);
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: write_reg(ADDR_FILL_VALUE, 32'h0000_0000);
                1: write_reg(ADDR_FILL_VALUE, 32'hFFFF_FFFF);
                2: write_reg(ADDR_FILL_VALUE, 32'h8000_0000);
                default: write_reg(ADDR_FILL_VALUE, $urandom);
            endcase
            write_reg(ADDR_FILL_ENABLE, ($urandom_range(0, 3) != 0 || phase < 2) ? 1 : 0);
            tx_gaps_on = (phase != 0) && (phase != 2);
            rx_stalls_on = (phase != 0);
            if (phase == 2) hold_req++;
            total = 0;
            if (phase == 0) begin
                gen_row(70, 1'b1, n);
                total += n;
            end
            while (total < PHASE_PIXELS) begin
                case ($urandom_range(0, 19))
                    0: gen_row($urandom_range(60, 72), 1'b1, n);
                    1, 2, 3: gen_row($urandom_range(13, 40), 1'b1, n);
                    default: gen_row($urandom_range(1, 12), 1'b1, n);
                endcase
                total += n;
                if (phase == 4 && total >= PHASE_PIXELS / 2 && total - n < PHASE_PIXELS / 2)
                    wait_idle();
            end
            if ($urandom_range(0, 1) != 0) begin
                send(rand_nonzero(), 1'b0, 1'b0);
                gen_row($urandom_range(1, 4), 1'b0, n);
            end
            wait_idle();
        end

        send(rand_nonzero(), 1'b1, 1'b1);
        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && released_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
